// ----- design/lfbrq_pkg.sv -----
// Shared constants of the length-framed byte ring queue: command and status codes, field widths.
package lfbrq_pkg;

  localparam int CMD_W    = 2;
  localparam int LEN_W    = 7;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int SIZE_CFG_W = 11;
  localparam int PREFIX_BYTES = 4;
  localparam int RAW_W = 8 * PREFIX_BYTES;

  localparam logic [CMD_W-1:0] CMD_HDR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DATA = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOROOM  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CORRUPT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOOBIG  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_STRAY   = 3'd5;

endpackage

// ----- design/lfbrq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module lfbrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/length_framed_byte_ring_queue.sv -----
// Top level of the length-framed byte ring queue: command sequencer, pointers and ring RAM.
//
// Messages live in a byte ring as a 4-byte little-endian length followed by the message bytes.
// A request is taken at a rising edge where start is high and busy is low; cmd selects a
// header (opens a message of msg_length bytes), a data byte (data_byte), or a pop with room
// capacity. Every result is shown for one cycle with done high and cannot be held off.
// A data byte request gives its result in the cycle after acceptance and leaves busy low.
// A header request that fits writes its four prefix bytes through the single RAM write port,
// one per cycle, and gives its result after the fourth write.
// A pop request that fails its first checks answers in the next cycle. Otherwise it reads
// the four prefix bytes through the RAM read port, waits in S_LAT for the last read, checks
// the length in S_CHK, and then reads one message byte per cycle; each byte appears with done
// in the cycle after its read, the final one with last high. Every other result has last high.
// Writing ring_size (cfg_wr_en) empties the queue and drops an open message.
// Reset empties the queue and sets ring_size to DEPTH, at most 1024; the ring storage is not cleared.
module length_framed_byte_ring_queue
  import lfbrq_pkg::*;
#(
  parameter int DEPTH    = 1024,
  parameter int MAX_MSG  = 64,
  parameter int RESERVED = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [LEN_W-1:0]      msg_length,
  input  logic [BYTE_W-1:0]     data_byte,
  input  logic [LEN_W-1:0]      capacity,
  input  logic                  cfg_wr_en,
  input  logic [SIZE_CFG_W-1:0] cfg_wr_data,
  output logic                  done,
  output logic [STATUS_W-1:0]   status,
  output logic [BYTE_W-1:0]     out_byte,
  output logic [LEN_W-1:0]      out_length,
  output logic                  last
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH + 1);
  localparam int NW = ((SW > BYTE_W) ? SW : BYTE_W) + 1;
  localparam int DW = NW + 2;
  localparam int XW = (SW > SIZE_CFG_W) ? SW : SIZE_CFG_W;
  localparam logic [SW-1:0] SIZE_RST = SW'((DEPTH < 1024) ? DEPTH : 1024);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HDR  = 3'd1;
  localparam logic [2:0] S_PRE  = 3'd2;
  localparam logic [2:0] S_LAT  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]        state;
  logic [SW-1:0]     size_q;
  logic [AW-1:0]     head_ptr;
  logic [AW-1:0]     tail_ptr;
  logic [AW-1:0]     write_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [LEN_W-1:0]  bytes_remaining;
  logic              append_open;
  logic [LEN_W-1:0]  len_q;
  logic [LEN_W-1:0]  cap_q;
  logic [SW-1:0]     code_lim;
  logic [1:0]        cnt;
  logic [LEN_W-1:0]  ecnt;
  logic [LEN_W-1:0]  rlen;
  logic              pre_pend;
  logic              emit_q;
  logic [RAW_W-1:0]  raw;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [BYTE_W-1:0] rdata;

  logic [SW-1:0]        raw_free;
  logic [SW-1:0]        free_sp;
  logic signed [DW-1:0] used_bytes;
  logic [NW-1:0]        hdr_need;
  logic [LEN_W-1:0]     cap_eff;
  logic [AW-1:0]        wp_inc;
  logic [AW-1:0]        rp_inc;
  logic [SW:0]          skip_sum;
  logic [AW-1:0]        skip_ptr;
  logic                 len_bad;
  logic [SW-1:0]        size_new;

  function automatic logic [AW-1:0] adv1(input logic [AW-1:0] p, input logic [SW-1:0] s);
    logic [SW-1:0] inc;
    inc = SW'(p) + SW'(1);
    return (inc == s) ? '0 : AW'(inc);
  endfunction

  always_comb begin
    if (head_ptr == tail_ptr) begin
      raw_free = size_q;
    end else if (head_ptr > tail_ptr) begin
      raw_free = SW'(head_ptr) - SW'(tail_ptr);
    end else begin
      raw_free = SW'(head_ptr) + size_q - SW'(tail_ptr);
    end
    free_sp = (NW'(raw_free) > NW'(RESERVED)) ? SW'(raw_free - SW'(RESERVED)) : '0;
    used_bytes = DW'(size_q) - DW'(free_sp) - DW'(RESERVED);
    hdr_need = NW'(PREFIX_BYTES) + NW'(msg_length);
    cap_eff = (capacity > LEN_W'(MAX_MSG)) ? LEN_W'(MAX_MSG) : capacity;
    wp_inc = adv1(write_ptr, size_q);
    rp_inc = adv1(rd_ptr, size_q);
    skip_sum = (SW + 1)'(rd_ptr) + (SW + 1)'(raw[SW-1:0]);
    skip_ptr = (skip_sum >= (SW + 1)'(size_q)) ? AW'(skip_sum - (SW + 1)'(size_q))
                                                : AW'(skip_sum);
    len_bad = raw[RAW_W-1] || (raw == '0) || (raw > RAW_W'(code_lim));
    if (XW'(cfg_wr_data) < XW'(16)) begin
      size_new = SW'(16);
    end else if (XW'(cfg_wr_data) > XW'(DEPTH)) begin
      size_new = SW'(DEPTH);
    end else begin
      size_new = SW'(cfg_wr_data);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = write_ptr;
    ram_wdata = data_byte;
    if (state == S_IDLE && start && cmd == CMD_DATA && append_open && !cfg_wr_en) begin
      ram_we = 1'b1;
    end else if (state == S_HDR && !cfg_wr_en) begin
      ram_we    = 1'b1;
      ram_wdata = (cnt == 2'd0) ? BYTE_W'(len_q) : '0;
    end
    ram_re = (state == S_PRE || state == S_EMIT);
  end

  lfbrq_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(rd_ptr),
    .rdata(rdata)
  );

  assign busy     = (state != S_IDLE);
  assign out_byte = emit_q ? rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      size_q          <= SIZE_RST;
      head_ptr        <= '0;
      tail_ptr        <= '0;
      write_ptr       <= '0;
      bytes_remaining <= '0;
      append_open     <= 1'b0;
      pre_pend        <= 1'b0;
      emit_q          <= 1'b0;
      done            <= 1'b0;
      last            <= 1'b0;
      status          <= ST_OK;
      out_length      <= '0;
    end else begin
      done       <= 1'b0;
      last       <= 1'b0;
      emit_q     <= 1'b0;
      status     <= ST_OK;
      out_length <= '0;
      pre_pend   <= 1'b0;
      if (pre_pend) begin
        raw <= {rdata, raw[RAW_W-1:BYTE_W]};
      end
      if (cfg_wr_en) begin
        size_q          <= size_new;
        head_ptr        <= '0;
        tail_ptr        <= '0;
        write_ptr       <= '0;
        bytes_remaining <= '0;
        append_open     <= 1'b0;
        state           <= S_IDLE;
      end else begin
        case (state)
          S_IDLE: begin
            if (start) begin
              case (cmd)
                CMD_HDR: begin
                  if (append_open || msg_length > LEN_W'(MAX_MSG)
                      || hdr_need > NW'(free_sp)) begin
                    done   <= 1'b1;
                    last   <= 1'b1;
                    status <= ST_NOROOM;
                  end else begin
                    write_ptr <= tail_ptr;
                    len_q     <= msg_length;
                    cnt       <= '0;
                    state     <= S_HDR;
                  end
                end
                CMD_DATA: begin
                  done <= 1'b1;
                  last <= 1'b1;
                  if (!append_open) begin
                    status <= ST_STRAY;
                  end else begin
                    write_ptr       <= wp_inc;
                    bytes_remaining <= bytes_remaining - LEN_W'(1);
                    if (bytes_remaining == LEN_W'(1)) begin
                      tail_ptr    <= wp_inc;
                      append_open <= 1'b0;
                    end
                  end
                end
                CMD_POP: begin
                  if (capacity == '0) begin
                    done   <= 1'b1;
                    last   <= 1'b1;
                    status <= ST_NOROOM;
                  end else if (head_ptr == tail_ptr) begin
                    done   <= 1'b1;
                    last   <= 1'b1;
                    status <= ST_EMPTY;
                  end else if (used_bytes < DW'(PREFIX_BYTES)) begin
                    done            <= 1'b1;
                    last            <= 1'b1;
                    status          <= ST_CORRUPT;
                    head_ptr        <= '0;
                    tail_ptr        <= '0;
                    write_ptr       <= '0;
                    bytes_remaining <= '0;
                    append_open     <= 1'b0;
                  end else begin
                    rd_ptr   <= head_ptr;
                    cap_q    <= cap_eff;
                    code_lim <= SW'(used_bytes - DW'(PREFIX_BYTES));
                    cnt      <= '0;
                    state    <= S_PRE;
                  end
                end
                default: begin
                end
              endcase
            end
          end
          S_HDR: begin
            write_ptr <= wp_inc;
            cnt       <= cnt + 2'd1;
            if (cnt == 2'd3) begin
              bytes_remaining <= len_q;
              if (len_q == '0) begin
                tail_ptr <= wp_inc;
              end else begin
                append_open <= 1'b1;
              end
              done  <= 1'b1;
              last  <= 1'b1;
              state <= S_IDLE;
            end
          end
          S_PRE: begin
            rd_ptr   <= rp_inc;
            pre_pend <= 1'b1;
            cnt      <= cnt + 2'd1;
            if (cnt == 2'd3) begin
              state <= S_LAT;
            end
          end
          S_LAT: begin
            state <= S_CHK;
          end
          S_CHK: begin
            if (len_bad) begin
              done            <= 1'b1;
              last            <= 1'b1;
              status          <= ST_CORRUPT;
              head_ptr        <= '0;
              tail_ptr        <= '0;
              write_ptr       <= '0;
              bytes_remaining <= '0;
              append_open     <= 1'b0;
              state           <= S_IDLE;
            end else if (raw > RAW_W'(cap_q)) begin
              done     <= 1'b1;
              last     <= 1'b1;
              status   <= ST_TOOBIG;
              head_ptr <= skip_ptr;
              state    <= S_IDLE;
            end else begin
              rlen  <= raw[LEN_W-1:0];
              ecnt  <= '0;
              state <= S_EMIT;
            end
          end
          S_EMIT: begin
            rd_ptr     <= rp_inc;
            ecnt       <= ecnt + LEN_W'(1);
            emit_q     <= 1'b1;
            done       <= 1'b1;
            out_length <= rlen;
            if (ecnt == rlen - LEN_W'(1)) begin
              last     <= 1'b1;
              head_ptr <= rp_inc;
              state    <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  a_open_has_bytes: assert property (@(posedge clk) disable iff (rst)
    append_open |-> bytes_remaining != '0)
    else $error("An open message has no bytes left to receive.");

  a_hdr_not_open: assert property (@(posedge clk) disable iff (rst)
    state == S_HDR |-> !append_open)
    else $error("A header is being written while a message is open.");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    SW'(head_ptr) < size_q && SW'(tail_ptr) < size_q)
    else $error("A ring pointer lies beyond the ring size.");

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && !cfg_wr_en |=> done && emit_q)
    else $error("A message byte read did not produce a result.");

endmodule
